@@ design/tref_pkg.sv @@
// Shared types, constants and field layouts of the touch report event filter.
package tref_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CoordW = 12;
  localparam int unsigned ReportW = 56;

  localparam logic [15:0] DefaultTimeout = 16'd50;

  // Configuration register indexes.
  localparam logic CfgStaleTimeout   = 1'b0;
  localparam logic CfgMissingTimeout = 1'b1;

  // Event flag values in bits 7:6 of report byte 3.
  localparam logic [1:0] FlagDown    = 2'b00;
  localparam logic [1:0] FlagLift    = 2'b01;
  localparam logic [1:0] FlagContact = 2'b10;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_END   = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic                interrupt_seen;
    logic [TimeW-1:0]    now_ms;
    logic                read_ok;
    logic [ReportW-1:0]  report;  // byte 0 in bits 7:0 up to byte 6 in bits 55:48
  } tref_item_t;

  typedef struct packed {
    logic                is_touching;
    logic [TimeW-1:0]    last_check_ms;
    logic [TimeW-1:0]    last_report_ms;
    logic [ReportW-1:0]  previous_report;
    logic [CoordW-1:0]   point_x;
    logic [CoordW-1:0]   point_y;
  } tref_state_t;

  typedef struct packed {
    logic [TimeoutW-1:0] stale_timeout_ms;
    logic [TimeoutW-1:0] missing_timeout_ms;
  } tref_cfg_t;

  typedef struct packed {
    event_kind_e         kind;
    logic [CoordW-1:0]   x_pos;
    logic [CoordW-1:0]   y_pos;
  } tref_result_t;

endpackage

@@ design/tref_core.sv @@
// Decision logic for one poll: next filter state and the result item.
module tref_core import tref_pkg::*; (
  input  tref_item_t   item_i,
  input  tref_state_t  state_i,
  input  tref_cfg_t    cfg_i,
  output tref_state_t  state_o,
  output tref_result_t result_o
);

  logic [TimeW-1:0]  check_age;
  logic [TimeW-1:0]  report_age;
  logic              stale_expired;
  logic              missing_expired;
  logic [7:0]        gesture;
  logic [3:0]        count;
  logic [1:0]        flag;
  logic [CoordW-1:0] new_x;
  logic [CoordW-1:0] new_y;

  // Differences wrap modulo 2^32, so a plain subtract does the job.
  assign check_age       = item_i.now_ms - state_i.last_check_ms;
  assign report_age      = item_i.now_ms - state_i.last_report_ms;
  assign stale_expired   = check_age >= {{(TimeW-TimeoutW){1'b0}}, cfg_i.stale_timeout_ms};
  assign missing_expired = report_age >= {{(TimeW-TimeoutW){1'b0}}, cfg_i.missing_timeout_ms};

  assign gesture = item_i.report[15:8];
  assign count   = item_i.report[19:16];
  assign flag    = item_i.report[31:30];
  assign new_x   = {item_i.report[27:24], item_i.report[39:32]};
  assign new_y   = {item_i.report[43:40], item_i.report[55:48]};

  always_comb begin
    state_o          = state_i;
    result_o.kind    = KIND_NONE;
    result_o.x_pos   = '0;
    result_o.y_pos   = '0;
    state_o.last_check_ms = item_i.now_ms;

    if (!item_i.interrupt_seen) begin
      if (state_i.is_touching && missing_expired) begin
        state_o.is_touching = 1'b0;
        result_o.kind  = KIND_END;
        result_o.x_pos = state_i.point_x;
        result_o.y_pos = state_i.point_y;
      end
    end else if (!state_i.is_touching && stale_expired) begin
      // A stale interrupt only refreshes the check time.
    end else if (item_i.read_ok) begin
      state_o.last_report_ms = item_i.now_ms;
      if (item_i.report != state_i.previous_report) begin
        state_o.previous_report = item_i.report;
        if (gesture == 8'd0) begin
          state_o.point_x = new_x;
          state_o.point_y = new_y;
          if (count == 4'd1 && flag == FlagDown) begin
            state_o.is_touching = 1'b1;
            result_o.kind = KIND_START;
          end else if (count == 4'd1 && flag == FlagContact) begin
            result_o.kind = KIND_MOVE;
          end else if (count == 4'd0 && flag == FlagLift) begin
            state_o.is_touching = 1'b0;
            result_o.kind = KIND_END;
          end
          if (result_o.kind != KIND_NONE) begin
            result_o.x_pos = new_x;
            result_o.y_pos = new_y;
          end
        end
      end
    end
  end

endmodule

@@ design/touch_report_event_filter.sv @@
// Top level of the touch report event filter: stream ports, registers and checks.

// One poll enters per cycle while the output is not stalled and gives exactly
// one result item: the poll is captured in an input register, the filter
// state and the result register are updated from it when the result register
// is free or being taken, and the result is offered on the master side. A
// stalled output holds the result register, and the input register then takes
// one more poll before the slave side stops. Both timeouts reset to 50 ms and
// may be written only while no poll is in flight.
module touch_report_event_filter import tref_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // now_ms, mode_byte, gesture_code, point_count_byte, x_high_byte,
  // x_low_byte, y_high_byte, y_low_byte
  input  logic [87:0] s_axis_tdata_i,
  // interrupt_seen, read_ok
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // x_pos, y_pos
  output logic [23:0] m_axis_tdata_o,
  // event_kind
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic         in_valid_q;
  tref_item_t   item_q;
  logic         out_valid_q;
  tref_result_t result_q;
  tref_result_t result_d;
  tref_state_t  state_q;
  tref_state_t  state_d;
  tref_cfg_t    cfg_q;
  logic         advance;
  logic         in_fire;
  logic         out_fire;

  assign out_fire        = out_valid_q && m_axis_tready_i;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  tref_core u_core (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_timeout_ms   <= DefaultTimeout;
      cfg_q.missing_timeout_ms <= DefaultTimeout;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStaleTimeout:   cfg_q.stale_timeout_ms   <= cfg_data_i;
        CfgMissingTimeout: cfg_q.missing_timeout_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.interrupt_seen <= s_axis_tuser_i[0];
      item_q.read_ok        <= s_axis_tuser_i[1];
      item_q.now_ms         <= s_axis_tdata_i[31:0];
      item_q.report         <= s_axis_tdata_i[87:32];
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {result_q.y_pos, result_q.x_pos};
  assign m_axis_tuser_o  = result_q.kind;

  // A result without an event carries a zero point.
  a_none_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.kind == KIND_NONE) |-> (m_axis_tdata_o == 24'd0))
    else $error("event-free result carries a nonzero point");

  // A start leaves the touch active, an end leaves it inactive.
  a_start_sets_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.kind == KIND_START) |=> state_q.is_touching)
    else $error("touch start did not mark the touch active");

  a_end_clears_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.kind == KIND_END) |=> !state_q.is_touching)
    else $error("touch end left the touch active");

  // A poll waiting in the input register is neither lost nor changed.
  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(item_q)))
    else $error("pending poll was dropped or overwritten");

  // The filter state moves only when a poll is processed.
  a_state_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("filter state changed without a processed poll");

endmodule
